// ----- hw/rtl/dtfm_pkg.sv -----
package dtfm_pkg;

    localparam int FRAME_W = 24;
    localparam int RATE_W  = 20;
    localparam int DIST_W  = 32;
    localparam int SEG_W   = 6;
    localparam int ACT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

    localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};
    localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_EMPTY      = 3'd1,
        STS_FULL       = 3'd2,
        STS_FRAME_DEC  = 3'd3,
        STS_ZERO_RATE  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_APP_MUL,
        ST_APP_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FETCH,
        ST_FETCH_WAIT,
        ST_DIV,
        ST_DIV_END,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic    load;
        logic    clear;
        logic    mul;
        logic    app_wr;
        logic    set_res;
        t_status res_status;
        logic    scan_init;
        logic    scan_chk;
        logic    rd_found;
        logic    fetch;
        logic    div_step;
        logic    div_end;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             empty;
        logic             full;
        logic             frame_dec;
        logic             scan_stop;
        logic             rate_zero;
        logic             div_last;
        logic             out_free;
    } t_sts;

endpackage

// ----- hw/rtl/dtfm_ram.sv -----
module dtfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/dtfm_ctrl.sv -----
module dtfm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  dtfm_pkg::t_sts i_sts,
    output dtfm_pkg::t_cmd o_cmd,
    output logic          o_idle
);
    import dtfm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                unique case (i_sts.action)
                    ACT_APPEND: begin
                        if (i_sts.full || i_sts.frame_dec) n_state = ST_FIN;
                        else n_state = ST_APP_MUL;
                    end
                    ACT_QUERY: begin
                        if (i_sts.empty) n_state = ST_FIN;
                        else n_state = ST_SCAN_RD;
                    end
                    default: n_state = ST_FIN;
                endcase
            end
            ST_APP_MUL:    n_state = ST_APP_WR;
            ST_APP_WR:     n_state = ST_FIN;
            ST_SCAN_RD:    n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (i_sts.scan_stop) n_state = ST_FETCH;
                else n_state = ST_SCAN_RD;
            end
            ST_FETCH:      n_state = ST_FETCH_WAIT;
            ST_FETCH_WAIT: begin
                if (i_sts.rate_zero) n_state = ST_FIN;
                else n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_sts.div_last) n_state = ST_DIV_END;
            end
            ST_DIV_END:    n_state = ST_FIN;
            ST_FIN: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.res_status = STS_OK;
        unique case (r_state)
            ST_IDLE: o_cmd.load = i_valid;
            ST_DECODE: begin
                o_cmd.set_res = 1'b1;
                unique case (i_sts.action)
                    ACT_CLEAR: o_cmd.clear = 1'b1;
                    ACT_APPEND: begin
                        if (i_sts.full) o_cmd.res_status = STS_FULL;
                        else if (i_sts.frame_dec) o_cmd.res_status = STS_FRAME_DEC;
                    end
                    ACT_QUERY: begin
                        if (i_sts.empty) o_cmd.res_status = STS_EMPTY;
                        else o_cmd.scan_init = 1'b1;
                    end
                    default: o_cmd.res_status = STS_OK;
                endcase
            end
            ST_APP_MUL:  o_cmd.mul = 1'b1;
            ST_APP_WR:   o_cmd.app_wr = 1'b1;
            ST_SCAN_CHK: o_cmd.scan_chk = 1'b1;
            ST_FETCH:    o_cmd.rd_found = 1'b1;
            ST_FETCH_WAIT: o_cmd.fetch = 1'b1;
            ST_DIV:      o_cmd.div_step = 1'b1;
            ST_DIV_END:  o_cmd.div_end = 1'b1;
            ST_FIN:      o_cmd.out_load = i_sts.out_free;
            default:     o_cmd.res_status = STS_OK;
        endcase
    end

    assign o_idle = (r_state == ST_IDLE);

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == ST_IDLE))
        else $error("item taken outside idle");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over a pending word");
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == ST_IDLE))
        else $error("controller did not return to idle");
endmodule

// ----- hw/rtl/dtfm_dp.sv -----
module dtfm_dp #(
    parameter int TABLE_DEPTH    = 64,
    parameter int DIST_FRAC_BITS = 8,
    parameter int RATE_FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dtfm_pkg::t_cmd                  i_cmd,
    output dtfm_pkg::t_sts                  o_sts,
    input  logic [dtfm_pkg::ACT_W-1:0]      i_action,
    input  logic [dtfm_pkg::FRAME_W-1:0]    i_entry_frame,
    input  logic [dtfm_pkg::RATE_W-1:0]     i_entry_rate,
    input  logic [dtfm_pkg::DIST_W-1:0]     i_query_distance,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [2:0]                      o_status,
    output logic [dtfm_pkg::FRAME_W-1:0]    o_frame_out,
    output logic [dtfm_pkg::RATE_W-1:0]     o_rate_out,
    output logic [dtfm_pkg::SEG_W-1:0]      o_segment_out,
    output logic [dtfm_pkg::DIST_W-1:0]     o_segment_start
);
    import dtfm_pkg::*;

    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int MW     = DIST_W + FRAME_W + RATE_W;
    localparam int PROD_W = FRAME_W + RATE_W;
    localparam int RSH    = (RATE_FRAC_BITS >= DIST_FRAC_BITS) ?
                            RATE_FRAC_BITS - DIST_FRAC_BITS : 0;
    localparam int LSH    = (DIST_FRAC_BITS > RATE_FRAC_BITS) ?
                            DIST_FRAC_BITS - RATE_FRAC_BITS : 0;
    localparam int INC_W  = PROD_W + LSH;
    localparam int NUM_W  = DIST_W + RATE_FRAC_BITS;
    localparam int DEN_W  = RATE_W + DIST_FRAC_BITS;
    localparam int DCW    = $clog2(NUM_W + 1);
    localparam int SW     = (AW > SEG_W) ? AW : SEG_W;

    logic [ACT_W-1:0]   r_action;
    logic [FRAME_W-1:0] r_frame;
    logic [RATE_W-1:0]  r_rate;
    logic [DIST_W-1:0]  r_dist;
    logic [CW-1:0]      r_count;
    logic [DIST_W-1:0]  r_running;
    logic [FRAME_W-1:0] r_prev_frame;
    logic [RATE_W-1:0]  r_prev_rate;
    logic [PROD_W-1:0]  r_prod;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      r_found;
    logic [FRAME_W-1:0] r_fr;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [DCW-1:0]     r_div_cnt;
    t_status            r_res_status;
    logic [FRAME_W-1:0] r_res_frame;
    logic [RATE_W-1:0]  r_res_rate;
    logic [AW-1:0]      r_res_seg;
    logic [DIST_W-1:0]  r_res_sd;
    logic               r_o_valid;
    t_status            r_o_status;
    logic [FRAME_W-1:0] r_o_frame;
    logic [RATE_W-1:0]  r_o_rate;
    logic [AW-1:0]      r_o_seg;
    logic [DIST_W-1:0]  r_o_sd;

    logic [MW-1:0]      rd_data;
    logic [DIST_W-1:0]  rd_sd;
    logic [FRAME_W-1:0] rd_frame;
    logic [RATE_W-1:0]  rd_rate;
    logic [AW-1:0]      raddr;
    logic [FRAME_W-1:0] diff;
    logic [INC_W-1:0]   inc;
    logic [INC_W:0]     total_wide;
    logic [DIST_W-1:0]  total;
    logic [DIST_W-1:0]  offset;
    logic [DEN_W:0]     shifted;
    logic               ge;
    logic [NUM_W:0]     fsum;
    logic [SW-1:0]      seg_ext;

    assign rd_sd    = rd_data[MW-1 -: DIST_W];
    assign rd_frame = rd_data[RATE_W +: FRAME_W];
    assign rd_rate  = rd_data[RATE_W-1:0];
    assign raddr    = i_cmd.rd_found ? r_found : r_idx;

    dtfm_ram #(.WIDTH(MW), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.app_wr),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({total, r_frame, r_rate}),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    assign diff = r_frame - r_prev_frame;
    assign inc  = (INC_W'(r_prod) >> RSH) << LSH;
    assign total_wide = (INC_W+1)'(r_running) + (INC_W+1)'(inc);

    always_comb begin
        if (r_count == '0) begin
            total = r_running;
        end else if (total_wide > (INC_W+1)'(DIST_MAX)) begin
            total = DIST_MAX;
        end else begin
            total = total_wide[DIST_W-1:0];
        end
    end

    assign offset  = (rd_sd <= r_dist) ? (r_dist - rd_sd) : '0;
    assign shifted = {r_rem, r_num[NUM_W-1]};
    assign ge      = (shifted >= {1'b0, r_den});
    assign fsum    = (NUM_W+1)'(r_fr) + {1'b0, r_num};

    assign o_sts.action    = r_action;
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.full      = (r_count == CW'(TABLE_DEPTH));
    assign o_sts.frame_dec = (r_count != '0) && (r_frame < r_prev_frame);
    assign o_sts.scan_stop = (rd_sd > r_dist) || ((CW'(r_idx) + 1'b1) == r_count);
    assign o_sts.rate_zero = (rd_rate == '0);
    assign o_sts.div_last  = (r_div_cnt == DCW'(1));
    assign o_sts.out_free  = !r_o_valid || !i_stall;

    // Control state with a defined reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_running    <= '0;
            r_prev_frame <= '0;
            r_prev_rate  <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count      <= '0;
                r_running    <= '0;
                r_prev_frame <= '0;
                r_prev_rate  <= '0;
            end else if (i_cmd.app_wr) begin
                r_count      <= r_count + 1'b1;
                r_running    <= total;
                r_prev_frame <= r_frame;
                r_prev_rate  <= r_rate;
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_frame  <= i_entry_frame;
            r_rate   <= i_entry_rate;
            r_dist   <= i_query_distance;
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
            r_res_frame  <= '0;
            r_res_rate   <= '0;
            r_res_seg    <= '0;
            r_res_sd     <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(diff) * PROD_W'(r_prev_rate);
        end
        if (i_cmd.app_wr) begin
            r_res_frame <= r_frame;
            r_res_rate  <= r_rate;
            r_res_seg   <= r_count[AW-1:0];
            r_res_sd    <= total;
        end
        if (i_cmd.scan_init) begin
            r_idx   <= '0;
            r_found <= '0;
        end
        if (i_cmd.scan_chk) begin
            if (!(rd_sd > r_dist)) r_found <= r_idx;
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.fetch) begin
            r_fr       <= rd_frame;
            r_res_rate <= rd_rate;
            r_res_seg  <= r_found;
            r_res_sd   <= rd_sd;
            r_num      <= NUM_W'(offset) << RATE_FRAC_BITS;
            r_den      <= DEN_W'(rd_rate) << DIST_FRAC_BITS;
            r_rem      <= '0;
            r_div_cnt  <= DCW'(NUM_W);
            if (rd_rate == '0) begin
                r_res_frame  <= FRAME_MAX;
                r_res_status <= STS_ZERO_RATE;
            end
        end
        if (i_cmd.div_step) begin
            r_rem     <= ge ? DEN_W'(shifted - {1'b0, r_den}) : shifted[DEN_W-1:0];
            r_num     <= {r_num[NUM_W-2:0], ge};
            r_div_cnt <= r_div_cnt - 1'b1;
        end
        if (i_cmd.div_end) begin
            r_res_frame <= (fsum > (NUM_W+1)'(FRAME_MAX)) ? FRAME_MAX : fsum[FRAME_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_res_status;
            r_o_frame  <= r_res_frame;
            r_o_rate   <= r_res_rate;
            r_o_seg    <= r_res_seg;
            r_o_sd     <= r_res_sd;
        end
    end

    assign seg_ext         = SW'(r_o_seg);
    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_frame_out     = r_o_frame;
    assign o_rate_out      = r_o_rate;
    assign o_segment_out   = seg_ext[SEG_W-1:0];
    assign o_segment_start = r_o_sd;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_chk |-> (CW'(r_idx) < r_count))
        else $error("scan read past last entry");
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.app_wr |-> (r_count < CW'(TABLE_DEPTH)))
        else $error("append into a full table");
endmodule

// ----- hw/rtl/distance_to_frame_map.sv -----
// Clear and unused action words, rejected appends and queries on an empty table go from
// decode to the output register; appends multiply and write, queries scan, fetch and divide.
// Throughput: one word at a time; the next word is taken once the controller is back
// in idle, even while the previous result still waits on a stalled output.
// The query time is set by the entry-by-entry scan of the table memory and the
// one-bit-per-cycle restoring divider. Reset (synchronous, active low) empties the table.
module distance_to_frame_map #(
    parameter int TABLE_DEPTH    = 64,
    parameter int DIST_FRAC_BITS = 8,
    parameter int RATE_FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [dtfm_pkg::ACT_W-1:0]   i_action,
    input  logic [dtfm_pkg::FRAME_W-1:0] i_entry_frame,
    input  logic [dtfm_pkg::RATE_W-1:0]  i_entry_rate,
    input  logic [dtfm_pkg::DIST_W-1:0]  i_query_distance,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_status,
    output logic [dtfm_pkg::FRAME_W-1:0] o_frame_out,
    output logic [dtfm_pkg::RATE_W-1:0]  o_rate_out,
    output logic [dtfm_pkg::SEG_W-1:0]   o_segment_out,
    output logic [dtfm_pkg::DIST_W-1:0]  o_segment_start
);
    import dtfm_pkg::*;

    // The controller sequences each word: decode, then, where needed, either the append path
    // (multiply the elapsed frames by the previous rate, then add with saturation
    // and write the breakpoint) or the query path (linear scan for the last
    // breakpoint at or below the distance, fetch it, then divide).
    t_cmd cmd;
    t_sts sts;
    logic idle;

    dtfm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_idle  (idle)
    );

    // The datapath holds the breakpoint memory, the running totals, the divider
    // and the output register that parts the two handshakes.
    dtfm_dp #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .DIST_FRAC_BITS (DIST_FRAC_BITS),
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_action         (i_action),
        .i_entry_frame    (i_entry_frame),
        .i_entry_rate     (i_entry_rate),
        .i_query_distance (i_query_distance),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_frame_out      (o_frame_out),
        .o_rate_out       (o_rate_out),
        .o_segment_out    (o_segment_out),
        .o_segment_start  (o_segment_start)
    );

    // Input words are taken only while the controller is idle.
    assign o_stall = !idle;
endmodule

// ----- sim/distance_to_frame_map_tb.sv -----
module distance_to_frame_map_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtfm_pkg::*;

    localparam int DEPTH      = 64;
    localparam int ITEM_GOAL  = 950;
    localparam int LIMIT      = 1500000;
    localparam int DRAIN_WAIT = 300;

    // The one action code the block does not use.
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    // One expected result word of the block.
    typedef struct {
        t_status              status;
        logic [FRAME_W-1:0]   frame;
        logic [RATE_W-1:0]    rate;
        logic [SEG_W-1:0]     seg;
        logic [DIST_W-1:0]    start;
    } t_frame_answer;

    // The scoreboard keeps its own copy of the breakpoint table and works out,
    // for every accepted input word, the answer the block must give.
    class frame_map_scoreboard;
        logic [DIST_W-1:0]  seg_start_tbl [DEPTH];
        logic [FRAME_W-1:0] seg_frame_tbl [DEPTH];
        logic [RATE_W-1:0]  seg_rate_tbl  [DEPTH];
        int unsigned        stored;
        logic [DIST_W-1:0]  travelled;
        logic [FRAME_W-1:0] last_frame;
        logic [RATE_W-1:0]  last_rate;
        t_frame_answer      pending_answers [$];
        int unsigned        mismatches;

        function new();
            stored     = 0;
            travelled  = '0;
            last_frame = '0;
            last_rate  = '0;
            mismatches = 0;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            mismatches++;
            $display("%0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        endtask

        function void note_word(logic [ACT_W-1:0] act, logic [FRAME_W-1:0] frame,
                                logic [RATE_W-1:0] rate, logic [DIST_W-1:0] qdist);
            t_frame_answer a;
            logic [63:0]   total;
            logic [63:0]   num;
            logic [63:0]   den;
            logic [63:0]   sum;
            int unsigned   hit;
            a = '{STS_OK, '0, '0, '0, '0};
            if (act == ACT_CLEAR) begin
                stored     = 0;
                travelled  = '0;
                last_frame = '0;
                last_rate  = '0;
            end else if (act == ACT_APPEND) begin
                if (stored >= DEPTH) begin
                    a.status = STS_FULL;
                end else if (stored > 0 && frame < last_frame) begin
                    a.status = STS_FRAME_DEC;
                end else begin
                    total = {32'd0, travelled};
                    if (stored > 0) begin
                        // Frames times rate carries 16 fraction bits; drop 8 of them.
                        total += ((64'(frame - last_frame) * 64'(last_rate)) >> 8);
                        if (total > {32'd0, DIST_MAX}) total = {32'd0, DIST_MAX};
                    end
                    travelled             = total[DIST_W-1:0];
                    seg_start_tbl[stored] = travelled;
                    seg_frame_tbl[stored] = frame;
                    seg_rate_tbl[stored]  = rate;
                    last_frame            = frame;
                    last_rate             = rate;
                    a.frame = frame;
                    a.rate  = rate;
                    a.seg   = SEG_W'(stored);
                    a.start = travelled;
                    stored++;
                end
            end else if (act == ACT_QUERY) begin
                if (stored == 0) begin
                    a.status = STS_EMPTY;
                end else begin
                    hit = 0;
                    for (int i = 0; i < stored; i++) begin
                        if (seg_start_tbl[i] > qdist) break;
                        hit = i;
                    end
                    a.rate  = seg_rate_tbl[hit];
                    a.seg   = SEG_W'(hit);
                    a.start = seg_start_tbl[hit];
                    if (a.rate == '0) begin
                        a.frame  = FRAME_MAX;
                        a.status = STS_ZERO_RATE;
                    end else begin
                        num = (qdist >= a.start) ? (64'(qdist - a.start) << 16) : 64'd0;
                        den = 64'(a.rate) << 8;
                        sum = 64'(seg_frame_tbl[hit]) + num / den;
                        a.frame = (sum > 64'(FRAME_MAX)) ? FRAME_MAX : sum[FRAME_W-1:0];
                    end
                end
            end
            pending_answers.push_back(a);
        endfunction

        task check_word(logic [2:0] status, logic [FRAME_W-1:0] frame,
                        logic [RATE_W-1:0] rate, logic [SEG_W-1:0] seg,
                        logic [DIST_W-1:0] start);
            t_frame_answer a;
            if (pending_answers.size() == 0) begin
                report("unexpected result word, status", 64'(status), 64'd0);
            end else begin
                a = pending_answers.pop_front();
                if (status !== a.status) report("status", 64'(status), 64'(a.status));
                if (frame !== a.frame) report("frame_out", 64'(frame), 64'(a.frame));
                if (rate !== a.rate) report("rate_out", 64'(rate), 64'(a.rate));
                if (seg !== a.seg) report("segment_out", 64'(seg), 64'(a.seg));
                if (start !== a.start) report("segment_start", 64'(start), 64'(a.start));
            end
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [ACT_W-1:0]   i_action = ACT_CLEAR;
    logic [FRAME_W-1:0] i_entry_frame = '0;
    logic [RATE_W-1:0]  i_entry_rate = '0;
    logic [DIST_W-1:0]  i_query_distance = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [2:0]         o_status;
    logic [FRAME_W-1:0] o_frame_out;
    logic [RATE_W-1:0]  o_rate_out;
    logic [SEG_W-1:0]   o_segment_out;
    logic [DIST_W-1:0]  o_segment_start;

    frame_map_scoreboard frame_sb = new();
    int unsigned         words_sent = 0;
    int unsigned         cycle_count = 0;
    bit                  calm = 1'b0;
    int unsigned         stall_left = 0;

    distance_to_frame_map i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_action         (i_action),
        .i_entry_frame    (i_entry_frame),
        .i_entry_rate     (i_entry_rate),
        .i_query_distance (i_query_distance),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_frame_out      (o_frame_out),
        .o_rate_out       (o_rate_out),
        .o_segment_out    (o_segment_out),
        .o_segment_start  (o_segment_start)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: a hung block or handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Mostly short idle stretches with the occasional long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The output side stalls in bursts whose lengths follow the same mix.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            stall_left = pick_gap();
            i_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // Every result word taken by the output handshake is checked in order.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            frame_sb.check_word(o_status, o_frame_out, o_rate_out, o_segment_out,
                                o_segment_start);
    end

    // Present one word, hold it until the block takes it, then maybe idle.
    // When no gap follows, valid simply stays high into the next word.
    task automatic send_word(logic [ACT_W-1:0] act, logic [FRAME_W-1:0] frame,
                             logic [RATE_W-1:0] rate, logic [DIST_W-1:0] qdist);
        int unsigned gap;
        i_valid          <= 1'b1;
        i_action         <= act;
        i_entry_frame    <= frame;
        i_entry_rate     <= rate;
        i_query_distance <= qdist;
        do @(posedge i_clk); while (o_stall);
        frame_sb.note_word(act, frame, rate, qdist);
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Rates: zero, tiny, full scale, or anything in between.
    function automatic logic [RATE_W-1:0] pick_rate();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return RATE_W'($urandom_range(1, 16));
        if (r == 2) return {RATE_W{1'b1}};
        return RATE_W'($urandom);
    endfunction

    // Frame steps: none, short, or huge enough to saturate the distance sum.
    function automatic logic [FRAME_W-1:0] pick_step();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r < 6) return FRAME_W'($urandom_range(1, 2000));
        if (r < 9) return FRAME_W'($urandom_range(1, 200000));
        return FRAME_W'($urandom);
    endfunction

    // Query distances mostly land around a stored breakpoint start, so the
    // search boundary and the offset arithmetic are both exercised.
    function automatic logic [DIST_W-1:0] pick_distance();
        int unsigned       r;
        logic [DIST_W-1:0] base;
        r = $urandom_range(0, 9);
        if (frame_sb.stored == 0 || r < 2) return $urandom;
        base = frame_sb.seg_start_tbl[$urandom_range(0, frame_sb.stored - 1)];
        if (r == 2) return base;
        if (r == 3) return base - 1;
        if (r == 4) return DIST_MAX;
        return base + DIST_W'($urandom_range(0, 1 << $urandom_range(0, 28)));
    endfunction

    // A well-formed sequence: clear, a run of rising breakpoints with some
    // broken ones mixed in, then a burst of lookups.
    task automatic run_sequence(bit fill);
        int unsigned        n_app;
        int unsigned        n_qry;
        logic [FRAME_W-1:0] frame;
        logic [FRAME_W-1:0] step;
        n_app = fill ? DEPTH + 2 : $urandom_range(1, 8);
        n_qry = $urandom_range(2, 10);
        frame = ($urandom_range(0, 3) == 0) ? FRAME_W'($urandom) : FRAME_W'($urandom_range(0, 99));
        send_word(ACT_CLEAR, FRAME_W'($urandom), RATE_W'($urandom), $urandom);
        if ($urandom_range(0, 7) == 0)
            send_word(ACT_QUERY, FRAME_W'($urandom), RATE_W'($urandom), $urandom);
        for (int i = 0; i < n_app; i++) begin
            if (i > 0 && $urandom_range(0, 9) == 0 && frame > 0) begin
                send_word(ACT_APPEND, frame - FRAME_W'($urandom_range(1, frame)),
                          pick_rate(), $urandom);
            end else begin
                step = pick_step();
                frame = (FRAME_MAX - frame < step) ? FRAME_MAX : frame + step;
                send_word(ACT_APPEND, frame, pick_rate(), $urandom);
            end
        end
        for (int i = 0; i < n_qry; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_word(ACT_SPARE, FRAME_W'($urandom), RATE_W'($urandom), $urandom);
            else
                send_word(ACT_QUERY, FRAME_W'($urandom), RATE_W'($urandom),
                          pick_distance());
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: empty table, zero rate, extreme fields, a frame going
        // backward, the unused action code and a saturated frame.
        send_word(ACT_QUERY, '0, '0, '0);
        send_word(ACT_APPEND, '0, '0, '0);
        send_word(ACT_QUERY, '0, '0, DIST_MAX);
        send_word(ACT_CLEAR, FRAME_MAX, {RATE_W{1'b1}}, DIST_MAX);
        send_word(ACT_QUERY, FRAME_MAX, {RATE_W{1'b1}}, DIST_MAX);
        send_word(ACT_APPEND, '0, {RATE_W{1'b1}}, '0);
        send_word(ACT_APPEND, FRAME_MAX, {RATE_W{1'b1}}, DIST_MAX);
        send_word(ACT_APPEND, FRAME_MAX - 1, 20'd1, '0);
        send_word(ACT_QUERY, '0, '0, '0);
        send_word(ACT_QUERY, '0, '0, 32'd12345);
        send_word(ACT_QUERY, '0, '0, DIST_MAX);
        send_word(ACT_SPARE, FRAME_MAX, {RATE_W{1'b1}}, DIST_MAX);
        send_word(ACT_CLEAR, '0, '0, '0);
        send_word(ACT_APPEND, 24'd100, 20'd1, '0);
        send_word(ACT_QUERY, '0, '0, DIST_MAX);
        send_word(ACT_APPEND, 24'd100, 20'd0, '0);
        send_word(ACT_QUERY, '0, '0, 32'd0);
        send_word(ACT_APPEND, 24'd99, 20'd5, '0);
        send_word(ACT_APPEND, 24'd5000, 20'h10000, '0);
        send_word(ACT_QUERY, '0, '0, 32'd300);

        // Random sequences; the first one sends more appends than the table holds, and some run
        // with no idling on either side.
        run_sequence(1'b1);
        while (words_sent < ITEM_GOAL) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
                send_word(ACT_W'($urandom_range(0, 3)), FRAME_W'($urandom),
                          RATE_W'($urandom), $urandom);
            else
                run_sequence($urandom_range(0, 39) == 0);
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (frame_sb.pending_answers.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (frame_sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/dtfm_pkg.sv
hw/rtl/dtfm_ram.sv
hw/rtl/dtfm_ctrl.sv
hw/rtl/dtfm_dp.sv
hw/rtl/distance_to_frame_map.sv
sim/distance_to_frame_map_tb.sv
